// ===== rtl/bounded_uniform_rejection_sampler_top_defines.svh =====
// Assertion macros shared by the sampler RTL.
`ifndef BOUNDED_UNIFORM_REJECTION_SAMPLER_TOP_DEFINES_SVH
`define BOUNDED_UNIFORM_REJECTION_SAMPLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside of reset.
`define BUR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is never true outside of reset.
`define BUR_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define BUR_ASSERT(lbl, prop, msg)
`define BUR_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/bur_pkg.sv =====
// Types and constants shared by the bounded uniform rejection sampler.
package bur_pkg;

    localparam int WORD_W = 64;
    localparam int CNT_W  = $clog2(WORD_W + 1);

    localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};

    typedef logic [WORD_W-1:0] word_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_ZERO_BOUND = 2'd1,
        STAT_EXHAUSTED  = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_DIV_LIM,
        FSM_DIV_VAL,
        FSM_FINISH
    } fsm_state_t;

    // Request to the serial remainder unit.
    typedef struct packed {
        logic  start;
        word_t dividend;
    } div_req_t;

    // Status of the serial remainder unit.
    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/bur_div.sv =====
// Restoring remainder unit that takes one dividend bit per cycle.
module bur_div (
    input  logic              clk,
    input  logic              rst_n,
    input  bur_pkg::div_req_t req,
    input  bur_pkg::word_t    divisor,
    output bur_pkg::word_t    remainder,
    output bur_pkg::div_stat_t stat
);
    import bur_pkg::*;

    word_t            rem_reg;
    word_t            rem_next;
    word_t            dvd_reg;
    word_t            dvd_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;

    logic [WORD_W:0]  shifted;
    logic [WORD_W:0]  diff;

    // The partial remainder stays below the divisor, so one shifted-in bit
    // needs at most one subtraction.
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[WORD_W-1]};
        diff    = shifted - {1'b0, divisor};
    end

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = '0;
            dvd_next = req.dividend;
            cnt_next = CNT_W'(WORD_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
            dvd_next  = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign remainder = rem_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/bounded_uniform_rejection_sampler_top.sv =====
// Top level of the bounded uniform rejection sampler.
// A bound of 0 or 1 goes from the idle state straight to the finish state; any other bound
// first runs the limit pass and then the value pass of the remainder unit before finishing.
// A new transaction is taken only in the idle state, so the shared remainder unit serves one
// transaction at a time; a stalled output holds a result in the finish state until the slot frees.
// Reset (rst_n, asynchronous, active low) returns to idle, empties the output
// register and clears the attempt counter.
`include "bounded_uniform_rejection_sampler_top_defines.svh"

module bounded_uniform_rejection_sampler_top #(
    parameter int MAX_ATTEMPTS = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bur_pkg::word_t      random_word,
    input  bur_pkg::word_t      bound,
    output logic                out_valid,
    input  logic                out_stall,
    output bur_pkg::status_t    status,
    output bur_pkg::word_t      value
);
    import bur_pkg::*;

    // The attempt counter holds 0 .. MAX_ATTEMPTS-1; the rejection that would
    // reach MAX_ATTEMPTS produces the exhausted result instead.
    localparam int ATT_W = (MAX_ATTEMPTS > 1) ? $clog2(MAX_ATTEMPTS) : 1;
    localparam logic [ATT_W-1:0] ATT_LAST = ATT_W'(MAX_ATTEMPTS - 1);

    fsm_state_t       state_reg;
    fsm_state_t       state_next;
    word_t            word_reg;
    word_t            bound_reg;
    word_t            lim_rem_reg;
    logic [ATT_W-1:0] attempt_reg;
    logic [ATT_W-1:0] attempt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    status_t          status_reg;
    word_t            value_reg;

    div_req_t         div_req;
    div_stat_t        div_stat;
    word_t            div_rem;

    logic             in_take;
    logic             slot_free;
    logic             below_limit;
    logic             res_produce;
    status_t          res_status;
    word_t            res_value;
    logic             leave_finish;

    // One remainder unit serves both passes: first (2^64-1) mod bound, which
    // sets the rejection limit, then word mod bound, which is the value.
    bur_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .divisor   (bound_reg),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    assign in_take   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    // The limit is (2^64-1) - r, where r is the first remainder, and the
    // complement of r is exactly that difference.
    assign below_limit = (word_reg < ~lim_rem_reg);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_take)
                begin
                    state_next = (bound[WORD_W-1:1] == '0) ? FSM_FINISH : FSM_DIV_LIM;
                end
            end
            FSM_DIV_LIM:
            begin
                if (div_stat.done)
                begin
                    state_next = FSM_DIV_VAL;
                end
            end
            FSM_DIV_VAL:
            begin
                if (div_stat.done)
                begin
                    state_next = FSM_FINISH;
                end
            end
            FSM_FINISH:
            begin
                if (leave_finish)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Output and datapath control logic.
    always_comb
    begin
        in_stall         = (state_reg != FSM_IDLE);
        div_req.start    = 1'b0;
        div_req.dividend = WORD_MAX;
        res_produce      = 1'b0;
        res_status       = STAT_OK;
        res_value        = '0;

        if (state_reg == FSM_IDLE && in_take && bound[WORD_W-1:1] != '0)
        begin
            div_req.start = 1'b1;
        end
        if (state_reg == FSM_DIV_LIM && div_stat.done)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = word_reg;
        end

        // Bound zero and bound one ignore the word; otherwise the word is
        // either accepted or counts as one more rejected attempt.
        priority if (bound_reg == '0)
        begin
            res_produce = 1'b1;
            res_status  = STAT_ZERO_BOUND;
        end
        else if (bound_reg[WORD_W-1:1] == '0)
        begin
            res_produce = 1'b1;
        end
        else if (below_limit)
        begin
            res_produce = 1'b1;
            res_value   = div_rem;
        end
        else if (attempt_reg == ATT_LAST)
        begin
            res_produce = 1'b1;
            res_status  = STAT_EXHAUSTED;
        end
        else
        begin
            res_produce = 1'b0;
        end

        // A rejected word leaves at once; a result waits for a free output slot.
        leave_finish = (state_reg == FSM_FINISH) && (!res_produce || slot_free);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        attempt_next   = attempt_reg;
        if (leave_finish)
        begin
            if (res_produce)
            begin
                out_valid_next = 1'b1;
                attempt_next   = '0;
            end
            else
            begin
                attempt_next = attempt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            attempt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            attempt_reg   <= attempt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            word_reg  <= random_word;
            bound_reg <= bound;
        end
        if (state_reg == FSM_DIV_LIM && div_stat.done)
        begin
            lim_rem_reg <= div_rem;
        end
        if (leave_finish && res_produce)
        begin
            status_reg <= res_status;
            value_reg  <= res_value;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;

    // An accepted transaction always leaves the idle state on the next cycle.
    `BUR_ASSERT(a_accept_leaves_idle, in_take |=> (state_reg != FSM_IDLE), "accept stayed idle")

    // The remainder unit only finishes while the controller waits for it.
    `BUR_ASSERT(a_div_done_in_div, div_stat.done |-> (state_reg == FSM_DIV_LIM || state_reg == FSM_DIV_VAL), "stray divider completion")

    // Error results always carry a zero value.
    `BUR_ASSERT_NEVER(a_err_value_zero, out_valid_reg && status_reg != STAT_OK && value_reg != '0, "error with nonzero value")

    // The attempt counter never passes the last allowed count.
    `BUR_ASSERT_NEVER(a_attempt_range, attempt_reg > ATT_LAST, "attempt counter overflow")

    // A result from the divider path is always below its bound.
    `BUR_ASSERT_NEVER(a_value_below_bound, leave_finish && res_produce && res_status == STAT_OK && bound_reg != '0 && res_value >= bound_reg, "value not below bound")

endmodule

// ===== dv/tb_bounded_uniform_rejection_sampler_top.sv =====
// Self-checking testbench for the bounded uniform rejection sampler top level.
`timescale 1ns / 100ps

module tb_bounded_uniform_rejection_sampler_top;

    import bur_pkg::*;

    // Clock period, attempt limit of the block and run-length knobs.
    localparam int CLK_PERIOD    = 8;
    localparam int DRAW_ATTEMPTS = 128;
    localparam int DRAW_TOTAL    = 850;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int REPORT_LIMIT  = 10;

    localparam word_t HALF_WORD = 64'h8000_0000_0000_0000;

    // How a queued draw is checked: against the predictor, or against a result
    // (or the absence of one) typed straight into the stimulus table.
    typedef enum logic [1:0] {
        CHK_PREDICTED,
        CHK_RESULT,
        CHK_NONE
    } check_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_SOLID
    } stall_mode_t;

    typedef struct packed {
        word_t   word;
        word_t   bnd;
        check_t  chk;
        status_t st;
        word_t   val;
    } draw_t;

    typedef struct packed {
        status_t st;
        word_t   val;
    } draw_result_t;

    localparam int DIRECTED_ROWS = 24;

    // Directed stimulus. Typed rows cover reset, the field extremes and the zero-bound
    // error code; the remaining rows are checked against the predictor. Rejections of the
    // all-ones word against an all-ones bound build up attempts that a zero bound, a
    // bound of one or an accepted word must clear again, and the run of bounds near
    // half the word range changes the bound while attempts are still pending.
    draw_t directed_draws [DIRECTED_ROWS] = '{
        '{64'd0,                    64'd0,                    CHK_RESULT,
          STAT_ZERO_BOUND, 64'd0},
        '{WORD_MAX,                 64'd0,                    CHK_RESULT,
          STAT_ZERO_BOUND, 64'd0},
        '{WORD_MAX,                 64'd1,                    CHK_RESULT,
          STAT_OK,         64'd0},
        '{64'd0,                    64'd1,                    CHK_RESULT,
          STAT_OK,         64'd0},
        '{64'd0,                    WORD_MAX,                 CHK_RESULT,
          STAT_OK,         64'd0},
        '{WORD_MAX - 64'd1,         WORD_MAX,                 CHK_RESULT,
          STAT_OK,         WORD_MAX - 64'd1},
        '{WORD_MAX,                 WORD_MAX,                 CHK_NONE,
          STAT_OK,         64'd0},
        '{WORD_MAX,                 64'd2,                    CHK_PREDICTED,
          STAT_OK,         64'd0},
        '{64'd5,                    64'd2,                    CHK_RESULT,
          STAT_OK,         64'd1},
        '{WORD_MAX,                 WORD_MAX,                 CHK_NONE,
          STAT_OK,         64'd0},
        '{64'd0,                    64'd0,                    CHK_RESULT,
          STAT_ZERO_BOUND, 64'd0},
        '{WORD_MAX,                 WORD_MAX,                 CHK_NONE,
          STAT_OK,         64'd0},
        '{64'd7,                    64'd1,                    CHK_RESULT,
          STAT_OK,         64'd0},
        '{WORD_MAX,                 64'd2,                    CHK_PREDICTED,
          STAT_OK,         64'd0},
        '{WORD_MAX,                 HALF_WORD + 64'd1,        CHK_PREDICTED,
          STAT_OK,         64'd0},
        '{HALF_WORD,                HALF_WORD + 64'd1,        CHK_PREDICTED,
          STAT_OK,         64'd0},
        '{64'hDEAD_BEEF_0123_4567,  HALF_WORD,                CHK_PREDICTED,
          STAT_OK,         64'd0},
        '{WORD_MAX - 64'd1,         64'd3,                    CHK_PREDICTED,
          STAT_OK,         64'd0},
        '{64'h0123_4567_89AB_CDEF,  64'd10,                   CHK_PREDICTED,
          STAT_OK,         64'd0},
        '{WORD_MAX,                 WORD_MAX - 64'd1,         CHK_PREDICTED,
          STAT_OK,         64'd0},
        '{WORD_MAX - 64'd2,         WORD_MAX - 64'd1,         CHK_PREDICTED,
          STAT_OK,         64'd0},
        '{64'h5555_5555_5555_5555,  64'hAAAA_AAAA_AAAA_AAAA,  CHK_PREDICTED,
          STAT_OK,         64'd0},
        '{WORD_MAX,                 64'd3,                    CHK_PREDICTED,
          STAT_OK,         64'd0},
        '{64'd0,                    64'd2,                    CHK_PREDICTED,
          STAT_OK,         64'd0}
    };

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    word_t    random_word;
    word_t    bound;
    logic     out_valid;
    logic     out_stall;
    status_t  status;
    word_t    value;

    // Draws waiting to be offered, the draw on the input port, and the results
    // that accepted draws still owe.
    draw_t        draw_queue [$];
    draw_t        cur_draw;
    draw_result_t pending_results [$];

    // Predictor state: words rejected since the last result.
    int unsigned draw_attempts = 0;

    int          fail_count  = 0;
    int          idle_cycles = 0;
    int          gap_left    = 0;
    int          burst_left  = 1;
    stall_mode_t stall_mode  = STALL_NONE;
    int          stall_left  = 0;

    bounded_uniform_rejection_sampler_top #(
        .MAX_ATTEMPTS (DRAW_ATTEMPTS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .random_word (random_word),
        .bound       (bound),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .value       (value)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Largest multiple of the bound that fits in a word; words at or above it are
    // rejected so that the remainder stays uniform.
    function automatic word_t acceptance_limit(input word_t bnd);
        return (WORD_MAX / bnd) * bnd;
    endfunction

    // Predicts one draw. Returns 1 when the draw produces a result and updates the
    // running attempt count the same way the block must.
    function automatic bit predict_draw(input word_t word, input word_t bnd,
                                        output status_t st, output word_t val);
        st  = STAT_OK;
        val = '0;
        if (bnd == 64'd0)
        begin
            st            = STAT_ZERO_BOUND;
            draw_attempts = 0;
            return 1'b1;
        end
        if (bnd == 64'd1)
        begin
            draw_attempts = 0;
            return 1'b1;
        end
        if (word < acceptance_limit(bnd))
        begin
            val           = word % bnd;
            draw_attempts = 0;
            return 1'b1;
        end
        draw_attempts++;
        if (draw_attempts >= DRAW_ATTEMPTS)
        begin
            st            = STAT_EXHAUSTED;
            draw_attempts = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    // Bounds of every shape: zero, one, tiny, powers of two, around half the word
    // range (where nearly half of all words get rejected), near all ones, and
    // random values of random magnitude.
    function automatic word_t rand_bound();
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return 64'd1;
            2:       return word_t'($urandom_range(2, 20));
            3:       return word_t'(1) << $urandom_range(1, 63);
            4:       return HALF_WORD + word_t'($urandom_range(0, 6)) - 64'd3;
            5:       return WORD_MAX - word_t'($urandom_range(0, 3));
            6:       return rand_word() >> $urandom_range(0, 63);
            default: return rand_word();
        endcase
    endfunction

    // A bound that takes the division path.
    function automatic word_t rand_div_bound();
        word_t bnd;
        bnd = rand_bound();
        return (bnd < 64'd2) ? bnd + 64'd2 : bnd;
    endfunction

    // A word the given bound (at least two) rejects. The rejected range is never
    // empty, since the all-ones word is always at or above the limit.
    function automatic word_t reject_word(input word_t bnd);
        word_t lim;
        lim = acceptance_limit(bnd);
        return lim + rand_word() % (WORD_MAX - lim + 64'd1);
    endfunction

    function automatic word_t accept_word(input word_t bnd);
        return rand_word() % acceptance_limit(bnd);
    endfunction

    task automatic queue_draw(input word_t word, input word_t bnd);
        draw_t d;
        d.word = word;
        d.bnd  = bnd;
        d.chk  = CHK_PREDICTED;
        d.st   = STAT_OK;
        d.val  = '0;
        draw_queue.push_back(d);
    endtask

    task automatic log_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s", $time, what);
        end
    endtask

    // Builds the whole stimulus up front. Most random traffic consists of rejection
    // runs: one run always goes all the way to exhaustion and one stops a single
    // attempt short of it, later runs have random lengths, and a run may switch its
    // bound halfway while the attempt count carries over. Runs that stop short end
    // with an accepted word, a zero bound or a bound of one, each of which must
    // clear the count. Single draws with any bound and any word fill the rest.
    initial
    begin : gen_stimulus
        int    seq;
        int    kind;
        int    run_len;
        word_t bnd;
        word_t word;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        random_word = '0;
        bound       = '0;
        out_stall   = 1'b0;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            draw_queue.push_back(directed_draws[i]);
        end

        seq = 0;
        while (draw_queue.size() < DRAW_TOTAL)
        begin
            if (seq == 0)
            begin
                kind = 0;
            end
            else if (seq == 1)
            begin
                kind = 5;
            end
            else
            begin
                kind = $urandom_range(0, 99);
            end

            if (kind < 3)
            begin
                // Full run of rejections up to exhaustion.
                bnd = rand_div_bound();
                repeat (DRAW_ATTEMPTS)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        bnd = rand_div_bound();
                    end
                    queue_draw(reject_word(bnd), bnd);
                end
            end
            else if (kind < 15)
            begin
                // Rejections that stop short of exhaustion, then a clearing result.
                if (seq == 1)
                begin
                    run_len = DRAW_ATTEMPTS - 1;
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    run_len = $urandom_range(1, 5);
                end
                else
                begin
                    run_len = $urandom_range(100, DRAW_ATTEMPTS - 1);
                end
                bnd = rand_div_bound();
                repeat (run_len)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        bnd = rand_div_bound();
                    end
                    queue_draw(reject_word(bnd), bnd);
                end
                case ($urandom_range(0, 3))
                    0:       queue_draw(rand_word(), 64'd0);
                    1:       queue_draw(rand_word(), 64'd1);
                    default: queue_draw(accept_word(bnd), bnd);
                endcase
            end
            else
            begin
                // Single draw, with the word sometimes placed on the limit.
                bnd = rand_bound();
                word = rand_word();
                if (bnd >= 64'd2)
                begin
                    case ($urandom_range(0, 9))
                        0:  word = reject_word(bnd);
                        1:  word = ($urandom_range(0, 1) == 0) ? 64'd0 : WORD_MAX;
                        2:  word = acceptance_limit(bnd) - 64'd1;
                        3:  word = acceptance_limit(bnd);
                        default: ;
                    endcase
                end
                queue_draw(word, bnd);
            end
            seq++;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every draw has been taken and every result has come back. A
        // trailing rejection produces nothing, so the drain covers a full division
        // pass and catches any stray result it might still emit.
        while (draw_queue.size() != 0 || in_valid || pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            log_failure($sformatf("%0d expected results never arrived",
                                  pending_results.size()));
        end

        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Input side. A transaction is taken at an edge where valid is high and stall is
    // low; only then does the predictor see the draw. The sender works in bursts of
    // random length, and each burst is followed by a gap that is often zero, often
    // a few cycles, and sometimes long enough to land anywhere inside the block's
    // two division passes. Valid is held, with a steady payload, until accepted.
    always @(posedge clk)
    begin : drive_draws
        logic         taken;
        logic         next_valid;
        bit           has_result;
        draw_result_t pred;
        draw_result_t typed;

        if (rst_n)
        begin
            taken = in_valid && !in_stall;
            if (taken)
            begin
                has_result = predict_draw(cur_draw.word, cur_draw.bnd, pred.st, pred.val);
                case (cur_draw.chk)
                    CHK_RESULT:
                    begin
                        typed.st  = cur_draw.st;
                        typed.val = cur_draw.val;
                        pending_results.push_back(typed);
                    end
                    CHK_NONE: ;
                    default:
                    begin
                        if (has_result)
                        begin
                            pending_results.push_back(pred);
                        end
                    end
                endcase
            end

            next_valid = in_valid && !taken;
            if (!next_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (draw_queue.size() != 0)
                begin
                    cur_draw = draw_queue.pop_front();
                    random_word <= cur_draw.word;
                    bound       <= cur_draw.bnd;
                    next_valid  = 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            4, 5, 6, 7: gap_left = $urandom_range(1, 4);
                            default:    gap_left = $urandom_range(0, 140);
                        endcase
                    end
                end
            end
            in_valid <= next_valid;
        end
    end

    // Output side stall pattern: segments of no stall, light or heavy random stall,
    // and short solid stalls, each segment of random length.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_left = (stall_mode == STALL_SOLID) ? $urandom_range(1, 40)
                                                         : $urandom_range(1, 300);
            end
            stall_left--;
            case (stall_mode)
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                STALL_SOLID: out_stall <= 1'b1;
                default:     out_stall <= 1'b0;
            endcase
        end
    end

    // Result checking and the watchdog. Every result transaction is matched with the
    // oldest expected result, field by field. The watchdog ends the run when no
    // transaction moves on either side for far longer than the slowest legal draw
    // with the longest sender gap and receiver stall.
    always @(posedge clk)
    begin : check_results
        draw_result_t want;

        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    log_failure($sformatf("unexpected result: status %0d value 0x%016h",
                                          status, value));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.st || value !== want.val)
                    begin
                        log_failure($sformatf(
                            "result mismatch: expected status %0d value 0x%016h, got %0d 0x%016h",
                            want.st, want.val, status, value));
                    end
                end
            end

            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end

            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
